>>> sv/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared constants and types for the box pair overlap finder.
// ----------------------------------------------------------------------------
package aabb_pkg;

	// width of a body id and of a raw coordinate field on the ports
	localparam int ID_BITS  = 32;
	localparam int RAW_BITS = 32;

	// scan sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST
	} scan_state_t;

endpackage

>>> sv/aabb_body_if.sv
// ----------------------------------------------------------------------------
// aabb_body_if
// Input channel: one rigid body box per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface aabb_body_if;
	import aabb_pkg::*;

	logic                        valid;
	logic                        ready;
	logic                        frame_start;
	logic                        present;
	logic                        is_static;
	logic [ID_BITS-1:0]          body_id;
	logic signed [RAW_BITS-1:0]  min_x;
	logic signed [RAW_BITS-1:0]  min_y;
	logic signed [RAW_BITS-1:0]  min_z;
	logic signed [RAW_BITS-1:0]  max_x;
	logic signed [RAW_BITS-1:0]  max_y;
	logic signed [RAW_BITS-1:0]  max_z;

	modport source (
		output valid, frame_start, present, is_static, body_id,
		output min_x, min_y, min_z, max_x, max_y, max_z,
		input  ready
	);

	modport sink (
		input  valid, frame_start, present, is_static, body_id,
		input  min_x, min_y, min_z, max_x, max_y, max_z,
		output ready
	);

endinterface

>>> sv/aabb_pair_if.sv
// ----------------------------------------------------------------------------
// aabb_pair_if
// Output channel: one overlapping body pair per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface aabb_pair_if;
	import aabb_pkg::*;

	logic               valid;
	logic               ready;
	logic [ID_BITS-1:0] earlier_id;
	logic [ID_BITS-1:0] later_id;
	logic               last_in_run;

	modport source (
		output valid, earlier_id, later_id, last_in_run,
		input  ready
	);

	modport sink (
		input  valid, earlier_id, later_id, last_in_run,
		output ready
	);

endinterface

>>> sv/aabb_ram.sv
// ----------------------------------------------------------------------------
// aabb_ram
// Generic single-write, single-read synchronous RAM with registered read.
// Read data holds while read enable is low.
// ----------------------------------------------------------------------------
module aabb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/aabb_pair_overlap_finder.sv
// ----------------------------------------------------------------------------
// aabb_pair_overlap_finder
// Brute-force broad phase: compares each incoming box with every box kept
// earlier in the frame and reports each overlapping pair, skipping pairs of two static bodies.
// ----------------------------------------------------------------------------
// Each word on body carries one box. A present body is checked against the
// K bodies kept so far in the frame (K at most MAX_BODIES): one stored entry
// is read from the body memory per cycle while the pair output is not held
// off by the consumer, and no further word is accepted until the final pair
// of the body has been loaded into the output register. An absent body
// starts no scan and leaves the block ready. Pairs for one body come out in
// store order with last_in_run set on the final pair; a body that overlaps
// nothing produces no word. frame_start empties the store before the body
// in the same word is handled. Once MAX_BODIES bodies are kept, later bodies
// are still checked but not stored, and at most MAX_BODIES - 1 pairs are
// reported per body. Coordinates are taken as the low min(COORD_BITS, 32)
// bits of each field, two's complement, bounds inclusive. No clearing pass
// follows reset: the store is tracked by a fill count.
// ----------------------------------------------------------------------------
module aabb_pair_overlap_finder #(
	parameter int MAX_BODIES = 64,
	parameter int COORD_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	aabb_body_if.sink    body,
	aabb_pair_if.source  pair
);
	import aabb_pkg::*;

	localparam int FB      = (COORD_BITS < RAW_BITS) ? COORD_BITS : RAW_BITS;
	localparam int AW      = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
	localparam int CW      = $clog2(MAX_BODIES + 1);
	localparam int HW      = $clog2(MAX_BODIES);
	localparam int MAX_RES = MAX_BODIES - 1;
	localparam int EW      = ID_BITS + 1 + 6 * FB;
	// entry layout, lowest first: min x/y/z, max x/y/z, static, id
	localparam int O_STAT  = 6 * FB;
	localparam int O_ID    = 6 * FB + 1;

	scan_state_t state_q, state_nx;

	logic [CW-1:0]      kept_count_q;
	logic [CW-1:0]      lim_q;
	logic [CW-1:0]      rd_idx_q;
	logic [CW-1:0]      cnt_base;
	logic [HW-1:0]      hits_q;
	logic               vld_s1;
	logic               pend_vld_q;
	logic [ID_BITS-1:0] pend_id_q;
	logic               out_vld_q;
	logic [ID_BITS-1:0] out_earlier_q;
	logic [ID_BITS-1:0] out_later_q;
	logic               out_last_q;

	// latched incoming body
	logic               static_q;
	logic [ID_BITS-1:0] id_q;
	logic signed [FB-1:0] mnx_q, mny_q, mnz_q, mxx_q, mxy_q, mxz_q;

	logic               accept;
	logic               store_room;
	logic               ram_we;
	logic [EW-1:0]      ram_wdata;
	logic               ram_re;
	logic [EW-1:0]      ram_rdata;
	logic               scan_more;
	logic               overlap;
	logic               hit_s1;
	logic               out_free;
	logic               advance;
	logic               load_mid;
	logic               load_last;

	logic signed [FB-1:0] k_mnx, k_mny, k_mnz, k_mxx, k_mxy, k_mxz;
	logic                 k_static;
	logic [ID_BITS-1:0]   k_id;

	// fill count after an optional frame clear
	assign cnt_base   = body.frame_start ? '0 : kept_count_q;
	assign store_room = (cnt_base < CW'(MAX_BODIES));
	assign accept     = body.valid && body.ready;

	// store the new body at the tail while the scan covers entries below it
	assign ram_we    = accept && body.present && store_room;
	assign ram_wdata = {body.body_id, body.is_static,
		body.max_z[FB-1:0], body.max_y[FB-1:0], body.max_x[FB-1:0],
		body.min_z[FB-1:0], body.min_y[FB-1:0], body.min_x[FB-1:0]};

	aabb_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_BODIES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_base[AW-1:0]),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// unpack stored entry
	assign k_mnx    = ram_rdata[0*FB +: FB];
	assign k_mny    = ram_rdata[1*FB +: FB];
	assign k_mnz    = ram_rdata[2*FB +: FB];
	assign k_mxx    = ram_rdata[3*FB +: FB];
	assign k_mxy    = ram_rdata[4*FB +: FB];
	assign k_mxz    = ram_rdata[5*FB +: FB];
	assign k_static = ram_rdata[O_STAT];
	assign k_id     = ram_rdata[O_ID +: ID_BITS];

	// inclusive overlap on all three axes
	assign overlap = (k_mnx <= mxx_q) && (mnx_q <= k_mxx)
		&& (k_mny <= mxy_q) && (mny_q <= k_mxy)
		&& (k_mnz <= mxz_q) && (mnz_q <= k_mxz);

	assign hit_s1 = vld_s1 && overlap && !(static_q && k_static)
		&& (hits_q != HW'(MAX_RES));

	// a new hit with a pair already pending needs the output register free
	assign out_free  = !out_vld_q || pair.ready;
	assign advance   = !(hit_s1 && pend_vld_q && !out_free);
	assign load_mid  = hit_s1 && pend_vld_q && out_free;
	assign load_last = (state_q == ST_LAST) && pend_vld_q && out_free;
	assign scan_more = (rd_idx_q < lim_q);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && body.present) begin
					state_nx = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!scan_more && !vld_s1) begin
					state_nx = ST_LAST;
				end
			end
			ST_LAST: begin
				if (!pend_vld_q || out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		body.ready = 1'b0;
		ram_re     = 1'b0;
		case (state_q)
			ST_IDLE: body.ready = 1'b1;
			ST_SCAN: ram_re     = advance && scan_more;
			ST_LAST: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// fill count, scan limit, read pointer and hit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_count_q <= '0;
			lim_q        <= '0;
			rd_idx_q     <= '0;
			hits_q       <= '0;
			vld_s1       <= 1'b0;
		end else begin
			if (accept) begin
				if (body.present) begin
					kept_count_q <= store_room ? cnt_base + CW'(1) : cnt_base;
				end else begin
					kept_count_q <= cnt_base;
				end
				lim_q    <= cnt_base;
				rd_idx_q <= '0;
				hits_q   <= '0;
				vld_s1   <= 1'b0;
			end else if (state_q == ST_SCAN && advance) begin
				vld_s1 <= scan_more;
				if (scan_more) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
				if (hit_s1) begin
					hits_q <= hits_q + HW'(1);
				end
			end
		end
	end

	// hold the incoming body for the scan
	always_ff @(posedge clk) begin
		if (accept) begin
			static_q <= body.is_static;
			id_q     <= body.body_id;
			mnx_q    <= body.min_x[FB-1:0];
			mny_q    <= body.min_y[FB-1:0];
			mnz_q    <= body.min_z[FB-1:0];
			mxx_q    <= body.max_x[FB-1:0];
			mxy_q    <= body.max_y[FB-1:0];
			mxz_q    <= body.max_z[FB-1:0];
		end
	end

	// pending pair: held back one hit so the final one can be marked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
		end else if (hit_s1 && advance) begin
			pend_vld_q <= 1'b1;
		end else if (load_last) begin
			pend_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_s1 && advance) begin
			pend_id_q <= k_id;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_mid || load_last) begin
			out_vld_q <= 1'b1;
		end else if (pair.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_mid || load_last) begin
			out_earlier_q <= pend_id_q;
			out_later_q   <= id_q;
			out_last_q    <= load_last;
		end
	end

	assign pair.valid       = out_vld_q;
	assign pair.earlier_id  = out_earlier_q;
	assign pair.later_id    = out_later_q;
	assign pair.last_in_run = out_last_q;

	// checks
	a_hits_cap: assert property (@(posedge clk) disable iff (!arst_n)
		hits_q <= HW'(MAX_RES))
		else $error("pair count per body over limit");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		kept_count_q <= CW'(MAX_BODIES))
		else $error("fill count over store depth");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_idx_q <= lim_q)
		else $error("read pointer past scan limit");

	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> state_q != ST_IDLE)
		else $error("pending pair left behind in idle");

	a_read_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> state_q == ST_SCAN)
		else $error("read data valid outside scan");

endmodule

>>> tb/tb_aabb_pair_overlap_finder.sv
// ----------------------------------------------------------------------------
// tb_aabb_pair_overlap_finder
// Self-checking bench for the box pair overlap finder. A queue of body words
// feeds a driver with random gaps. Each accepted body is run through a local
// copy of the body store to build the pairs it should cause. A monitor with
// random stalls compares each pair word, field by field, with the oldest
// pair still due. Directed words cover the corner cases. Random frames
// follow, mostly small and sparse, with two crowded frames that fill the
// store and overrun the per-body pair limit.
// ----------------------------------------------------------------------------
module tb_aabb_pair_overlap_finder;
	import aabb_pkg::*;

	localparam int MAX_BODIES  = 64;
	localparam int COORD_BITS  = 32;
	localparam int FIELD_BITS  = (COORD_BITS < RAW_BITS) ? COORD_BITS : RAW_BITS;
	localparam int UNIT        = 65536;
	localparam int BODY_TARGET = 480;
	localparam int LONG_IDLE   = 30;
	// every word at its worst: full scan, every pair held by the longest stall
	localparam longint CYCLE_LIMIT = 64'd3 * 600 *
		(MAX_BODIES + 4 + LONG_IDLE + (MAX_BODIES - 1) * (LONG_IDLE + 1));

	typedef struct packed {
		logic                frame_start;
		logic                present;
		logic                is_static;
		logic [ID_BITS-1:0]  body_id;
		logic [RAW_BITS-1:0] min_x;
		logic [RAW_BITS-1:0] min_y;
		logic [RAW_BITS-1:0] min_z;
		logic [RAW_BITS-1:0] max_x;
		logic [RAW_BITS-1:0] max_y;
		logic [RAW_BITS-1:0] max_z;
	} body_word_t;

	typedef struct packed {
		logic [ID_BITS-1:0] earlier_id;
		logic [ID_BITS-1:0] later_id;
		logic               last_in_run;
	} pair_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	aabb_body_if body_ch ();
	aabb_pair_if pair_ch ();

	aabb_pair_overlap_finder #(
		.MAX_BODIES(MAX_BODIES),
		.COORD_BITS(COORD_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.body(body_ch),
		.pair(pair_ch)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	body_word_t bodies_to_send[$];
	pair_word_t pairs_due[$];
	body_word_t kept_box[MAX_BODIES];
	int         kept_n;

	body_word_t in_flight;
	int         send_gap;
	int         hold_gap;
	logic       calm;
	longint     cycle_count;
	int         words_sent;
	int         words_taken;
	int         pairs_checked;
	int         capped_runs;
	int         mismatches;
	int         absent_words;
	int         frames;

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// low FIELD_BITS of a raw bound, two's complement
	function automatic longint coord(logic [RAW_BITS-1:0] raw);
		logic [63:0] v;
		v = 64'(raw) & ((64'd1 << FIELD_BITS) - 64'd1);
		if (v[FIELD_BITS-1])
			v = v - (64'd1 << FIELD_BITS);
		return longint'(v);
	endfunction

	function automatic bit boxes_touch(body_word_t a, body_word_t b);
		return coord(a.min_x) <= coord(b.max_x) && coord(b.min_x) <= coord(a.max_x) &&
			coord(a.min_y) <= coord(b.max_y) && coord(b.min_y) <= coord(a.max_y) &&
			coord(a.min_z) <= coord(b.max_z) && coord(b.min_z) <= coord(a.max_z);
	endfunction

	// compare one accepted body against the store, queue its pairs, keep it
	task automatic predict_pairs(body_word_t w);
		pair_word_t found[$];
		pair_word_t p;
		int i;
		if (w.frame_start)
			kept_n = 0;
		if (!w.present)
			return;
		for (i = 0; i < kept_n; i++) begin
			if (w.is_static && kept_box[i].is_static)
				continue;
			if (!boxes_touch(kept_box[i], w))
				continue;
			if (found.size() >= MAX_BODIES - 1) begin
				capped_runs++;
				break;
			end
			p.earlier_id = kept_box[i].body_id;
			p.later_id = w.body_id;
			p.last_in_run = 1'b0;
			found = {found, p};
		end
		if (found.size() != 0)
			found[found.size() - 1].last_in_run = 1'b1;
		pairs_due = {pairs_due, found};
		if (kept_n < MAX_BODIES) begin
			kept_box[kept_n] = w;
			kept_n++;
		end
	endtask

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// append one word to the send queue
	function automatic void queue_body(body_word_t w);
		bodies_to_send = {bodies_to_send, w};
	endfunction

	// idle length: mostly none, some short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, LONG_IDLE);
	endfunction

	function automatic body_word_t body_at(bit fs, bit pr, bit st, logic [ID_BITS-1:0] id,
		int lx, int ly, int lz, int hx, int hy, int hz);
		body_word_t w;
		w.frame_start = fs;
		w.present = pr;
		w.is_static = st;
		w.body_id = id;
		w.min_x = lx;
		w.min_y = ly;
		w.min_z = lz;
		w.max_x = hx;
		w.max_y = hy;
		w.max_z = hz;
		return w;
	endfunction

	// random body; crowded boxes all contain the origin so every pair meets
	function automatic body_word_t make_body(bit crowded);
		body_word_t w;
		logic [RAW_BITS-1:0] lo[3];
		logic [RAW_BITS-1:0] hi[3];
		int c;
		int h;
		int r;
		int ax;
		r = $urandom_range(0, 99);
		w.frame_start = 1'b0;
		w.present = crowded || ($urandom_range(0, 9) != 0);
		w.is_static = crowded ? ($urandom_range(0, 19) == 0) : ($urandom_range(0, 2) == 0);
		w.body_id = $urandom();
		for (ax = 0; ax < 3; ax++) begin
			if (crowded) begin
				lo[ax] = -int'($urandom_range(0, 1000 * UNIT));
				hi[ax] = $urandom_range(0, 1000 * UNIT);
			end else if (r < 8) begin
				lo[ax] = $urandom();
				hi[ax] = $urandom();
			end else begin
				c = int'($urandom_range(0, 80 * UNIT)) - 40 * UNIT;
				h = $urandom_range(0, 12 * UNIT);
				lo[ax] = c - h;
				hi[ax] = c + h;
			end
		end
		// flip one axis now and then
		if (!crowded && r >= 8 && r < 14) begin
			ax = $urandom_range(0, 2);
			{lo[ax], hi[ax]} = {hi[ax], lo[ax]};
		end
		w.min_x = lo[0];
		w.min_y = lo[1];
		w.min_z = lo[2];
		w.max_x = hi[0];
		w.max_y = hi[1];
		w.max_z = hi[2];
		return w;
	endfunction

	// ------------------------------------------------------------------
	// body driver
	// ------------------------------------------------------------------

	// known levels before the first edge
	initial begin
		body_ch.valid = 1'b0;
		body_ch.frame_start = 1'b0;
		body_ch.present = 1'b0;
		body_ch.is_static = 1'b0;
		body_ch.body_id = '0;
		body_ch.min_x = '0;
		body_ch.min_y = '0;
		body_ch.min_z = '0;
		body_ch.max_x = '0;
		body_ch.max_y = '0;
		body_ch.max_z = '0;
		pair_ch.ready = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_ch.valid <= 1'b0;
			send_gap = 0;
		end else begin
			// predict on acceptance
			if (body_ch.valid && body_ch.ready) begin
				predict_pairs(in_flight);
				words_taken++;
			end
			// advance to the next word once the slot is free
			if (!body_ch.valid || body_ch.ready) begin
				if (send_gap == 0 && bodies_to_send.size() != 0) begin
					in_flight = bodies_to_send.pop_front();
					body_ch.valid <= 1'b1;
					body_ch.frame_start <= in_flight.frame_start;
					body_ch.present <= in_flight.present;
					body_ch.is_static <= in_flight.is_static;
					body_ch.body_id <= in_flight.body_id;
					body_ch.min_x <= in_flight.min_x;
					body_ch.min_y <= in_flight.min_y;
					body_ch.min_z <= in_flight.min_z;
					body_ch.max_x <= in_flight.max_x;
					body_ch.max_y <= in_flight.max_y;
					body_ch.max_z <= in_flight.max_z;
					send_gap = idle_len();
				end else begin
					if (send_gap != 0)
						send_gap--;
					body_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// pair monitor
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_ch.ready <= 1'b0;
			hold_gap = 0;
		end else begin
			// check each accepted pair against the oldest one due
			if (pair_ch.valid === 1'b1 && pair_ch.ready) begin
				pairs_checked++;
				if (pairs_due.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected pair: earlier %h later %h last %b",
							pair_ch.earlier_id, pair_ch.later_id, pair_ch.last_in_run);
					mismatches++;
				end else begin
					pair_word_t due;
					due = pairs_due.pop_front();
					if (pair_ch.earlier_id !== due.earlier_id ||
						pair_ch.later_id !== due.later_id ||
						pair_ch.last_in_run !== due.last_in_run) begin
						if (mismatches < 10)
							$display("pair mismatch: expected %h %h %b, got %h %h %b",
								due.earlier_id, due.later_id, due.last_in_run,
								pair_ch.earlier_id, pair_ch.later_id, pair_ch.last_in_run);
						mismatches++;
					end
				end
			end
			// stall the consumer at random
			if (hold_gap != 0) begin
				hold_gap--;
				pair_ch.ready <= 1'b0;
			end else begin
				pair_ch.ready <= 1'b1;
				hold_gap = idle_len();
			end
		end
	end

	// cycle count and stretches with no idling on either side
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count % 300 == 0)
			calm <= ($urandom_range(0, 3) == 0);
	end

	// ------------------------------------------------------------------
	// timeout
	// ------------------------------------------------------------------
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("timeout after %0d cycles, %0d of %0d words taken, %0d pairs due",
			cycle_count, words_taken, words_sent, pairs_due.size());
		$display("end of test: mismatches");
		$finish;
	end

	// ------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		body_word_t w;
		int placed;
		int frame_len;
		int k;
		bit crowded;
		kept_n = 0;
		calm = 1'b0;
		cycle_count = 0;
		words_sent = 0;
		words_taken = 0;
		pairs_checked = 0;
		capped_runs = 0;
		mismatches = 0;
		absent_words = 0;
		frames = 0;

		// directed: absent word with frame start on an empty store
		queue_body(body_at(1, 0, 0, 32'h0, 0, 0, 0, 0, 0, 0));
		// moving box
		queue_body(body_at(0, 1, 0, 32'h1, 0, 0, 0,
			10 * UNIT, 10 * UNIT, 10 * UNIT));
		// absent word with junk content, ignored
		queue_body(body_at(0, 0, 1, 32'hDEAD_BEEF, 0, 0, 0,
			5 * UNIT, 5 * UNIT, 5 * UNIT));
		// static box touching the first one exactly on its upper bounds
		queue_body(body_at(0, 1, 1, 32'h2, 10 * UNIT, 10 * UNIT, 10 * UNIT,
			20 * UNIT, 20 * UNIT, 20 * UNIT));
		// static over static only: skipped
		queue_body(body_at(0, 1, 1, 32'h3, 15 * UNIT, 15 * UNIT, 15 * UNIT,
			25 * UNIT, 25 * UNIT, 25 * UNIT));
		// moving box meeting all three
		queue_body(body_at(0, 1, 0, 32'h4, 10 * UNIT, 10 * UNIT, 10 * UNIT,
			15 * UNIT, 15 * UNIT, 15 * UNIT));
		// full range box, all-ones id
		queue_body(body_at(0, 1, 0, 32'hFFFF_FFFF,
			int'(32'h8000_0000), int'(32'h8000_0000), int'(32'h8000_0000),
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		// full range static, zero id
		queue_body(body_at(0, 1, 1, 32'h0,
			int'(32'h8000_0000), int'(32'h8000_0000), int'(32'h8000_0000),
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		// inverted on x only
		queue_body(body_at(0, 1, 0, 32'h5, 10 * UNIT,
			int'(32'h8000_0000), int'(32'h8000_0000), 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		// inverted on every axis, at the extremes
		queue_body(body_at(0, 1, 0, 32'h6,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			int'(32'h8000_0000), int'(32'h8000_0000), int'(32'h8000_0000)));
		// miss the first box by one lsb on z, on y, and by 2 * UNIT on x
		queue_body(body_at(0, 1, 0, 32'h7, 0, 0, 10 * UNIT + 1,
			10 * UNIT, 10 * UNIT, 12 * UNIT));
		queue_body(body_at(0, 1, 0, 32'h8, 0, -5 * UNIT, 0,
			10 * UNIT, -1, 10 * UNIT));
		queue_body(body_at(0, 1, 0, 32'h9, -3 * UNIT - 1, 0, 0,
			-2 * UNIT, 10 * UNIT, 10 * UNIT));
		// new frame carried by a present body
		queue_body(body_at(1, 1, 0, 32'hA, -UNIT, -UNIT, -UNIT,
			UNIT, UNIT, UNIT));
		queue_body(body_at(0, 1, 1, 32'hB, 0, 0, 0, 2 * UNIT, 2 * UNIT, 2 * UNIT));
		// absent word that still empties the store
		queue_body(body_at(1, 0, 0, 32'hC, 0, 0, 0, 0, 0, 0));
		queue_body(body_at(0, 1, 0, 32'hD, 0, 0, 0, UNIT, UNIT, UNIT));

		placed = 0;
		foreach (bodies_to_send[i])
			if (bodies_to_send[i].present)
				placed++;
			else
				absent_words++;

		// random frames; two of them crowded past the store size
		while (placed < BODY_TARGET) begin
			crowded = (frames == 2 || frames == 7);
			frame_len = crowded ? MAX_BODIES + 4 : $urandom_range(1, 14);
			for (k = 0; k < frame_len; k++) begin
				w = make_body(crowded);
				if (crowded && k >= MAX_BODIES)
					w.is_static = 1'b0;
				w.frame_start = (k == 0) && (crowded || $urandom_range(0, 5) != 0);
				queue_body(w);
				if (w.present)
					placed++;
				else
					absent_words++;
			end
			frames++;
		end
		words_sent = bodies_to_send.size();

		// release reset away from the rising edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain
		while (words_taken < words_sent || pairs_due.size() != 0)
			@(posedge clk);
		repeat (MAX_BODIES + 8) @(posedge clk);

		if (pairs_due.size() != 0) begin
			$display("%0d pairs never arrived", pairs_due.size());
			mismatches += pairs_due.size();
		end
		$display("sent %0d words (%0d absent) over %0d random frames plus directed cases",
			words_sent, absent_words, frames);
		$display("checked %0d pairs, %0d bodies hit the per-body pair cap, %0d mismatches",
			pairs_checked, capped_runs, mismatches);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
